// ----- sv/rtp_pkg.sv -----
`default_nettype none
package rtp_pkg;

  localparam int QueueDepthDefault = 2;

  // Parse phases, one-hot.
  typedef enum logic [28:0] {
    PH_LEAD       = 29'd1 << 0,
    PH_Y1         = 29'd1 << 1,
    PH_Y2         = 29'd1 << 2,
    PH_Y3         = 29'd1 << 3,
    PH_DASH1      = 29'd1 << 4,
    PH_M0         = 29'd1 << 5,
    PH_M1         = 29'd1 << 6,
    PH_DASH2      = 29'd1 << 7,
    PH_D0         = 29'd1 << 8,
    PH_D1         = 29'd1 << 9,
    PH_AFTER_DATE = 29'd1 << 10,
    PH_DATE_WS    = 29'd1 << 11,
    PH_H0         = 29'd1 << 12,
    PH_H1         = 29'd1 << 13,
    PH_C1         = 29'd1 << 14,
    PH_MI0        = 29'd1 << 15,
    PH_MI1        = 29'd1 << 16,
    PH_C2         = 29'd1 << 17,
    PH_S0         = 29'd1 << 18,
    PH_S1         = 29'd1 << 19,
    PH_AFTER_SEC  = 29'd1 << 20,
    PH_FRAC_FIRST = 29'd1 << 21,
    PH_FRAC       = 29'd1 << 22,
    PH_OH0        = 29'd1 << 23,
    PH_OH1        = 29'd1 << 24,
    PH_OC         = 29'd1 << 25,
    PH_OM0        = 29'd1 << 26,
    PH_OM1        = 29'd1 << 27,
    PH_TAIL       = 29'd1 << 28
  } phase_t;

  // Back-end sequencer states, one-hot.
  typedef enum logic [5:0] {
    BS_IDLE  = 6'b000001,
    BS_DAYS  = 6'b000010,
    BS_DOE   = 6'b000100,
    BS_SECS  = 6'b001000,
    BS_FRAC  = 6'b010000,
    BS_OUT   = 6'b100000
  } bstate_t;

  // One classified literal, handed from the parser to the converter.
  typedef struct packed {
    logic        ok;
    logic        day_only;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] frac;
    logic [3:0]  frac_cnt;
    logic        off_neg;
    logic [4:0]  off_hour;
    logic [5:0]  off_minute;
  } lit_t;

  localparam logic [4:0] MonthLen [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                           5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  // Days before month (March-based year), i.e. (153*mm+2)/5.
  localparam logic [8:0] DoyBase [12] = '{9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
                                          9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337};

endpackage
`default_nettype wire

// ----- sv/rfc3339_timestamp_parser_top.sv -----
`default_nettype none
// Channel   Direction  Signals
// in_       input      in_valid, in_ready, in_char_byte, in_is_last
// out_      output     out_valid, out_ready, out_valid_res .. out_nanoseconds
//
// Characters are taken one per cycle; only a last character waits on queue space.
// The back end steps each literal through DAYS, DOE, SECS, FRAC and OUT, scaling
// the fraction one digit per cycle; literals queue two deep in between.
// Reset (rst_n low, synchronous) returns the parser to leading whitespace.
module rfc3339_timestamp_parser_top
  import rtp_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_valid_res,
  output logic [13:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic             out_day_only,
  output logic signed [38:0] out_epoch_seconds,
  output logic [29:0]      out_nanoseconds
);

  logic f_valid, f_ready, b_valid, b_ready;
  lit_t f_lit, b_lit;

  rtp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_char_byte, .in_is_last,
    .lit_valid(f_valid), .lit(f_lit), .lit_ready(f_ready)
  );

  rtp_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_lit),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_lit)
  );

  rtp_back u_back (
    .clk, .rst_n, .lit_valid(b_valid), .lit_ready(b_ready), .lit(b_lit),
    .out_valid, .out_ready, .out_valid_res, .out_year, .out_month, .out_day,
    .out_day_only, .out_epoch_seconds, .out_nanoseconds
  );

  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_epoch_seconds == '0 && out_year == '0)
    else $error("rejected literal carries data");
  a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_nanoseconds < 30'd1000000000)
    else $error("nanoseconds out of range");
  a_last_wait: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_is_last |-> in_ready)
    else $error("front stalled on a middle character");

endmodule
`default_nettype wire

// ----- sv/rtp_front.sv -----
`default_nettype none
module rtp_front
  import rtp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_is_last,
  output logic            lit_valid,
  output lit_t            lit,
  input  wire logic       lit_ready
);

  phase_t      phase_r, phase_nxt;
  logic        err_r, err_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  mon_r, mon_nxt, day_r, day_nxt, hr_r, hr_nxt, mi_r, mi_nxt, se_r, se_nxt;
  logic [6:0]  oh_r, oh_nxt, om_r, om_nxt;
  logic [29:0] fr_r, fr_nxt;
  logic [3:0]  fc_r, fc_nxt;
  logic        neg_r, neg_nxt;

  logic        is_ws, is_dig, leap, date_ok, ok, donly;
  logic [3:0]  dv;
  logic [4:0]  lim;
  logic [7:0]  c;
  logic        take;
  logic [26:0] ycent_prod;
  logic [7:0]  ycent;
  logic [13:0] yrem;

  assign c = in_char_byte;
  assign in_ready = lit_ready || !in_is_last;
  assign take = in_valid && in_ready;
  assign is_ws = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign is_dig = (c >= 8'h30) && (c <= 8'h39);
  assign dv = c[3:0];

  // The year is complete whenever a literal can be accepted, so the leap test
  // works from the registered year. Century and remainder come from a
  // reciprocal multiplication that is exact over the 14-bit range.
  assign ycent_prod = 27'(year_r) * 27'd5243;
  assign ycent = ycent_prod[26:19];
  assign yrem = year_r - 14'(ycent) * 14'd100;

  function automatic logic [6:0] sh7(input logic [6:0] a, input logic [3:0] d);
    sh7 = 7'((a << 3) + (a << 1) + 7'(d));
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    err_nxt = err_r;
    year_nxt = year_r;
    mon_nxt = mon_r; day_nxt = day_r; hr_nxt = hr_r; mi_nxt = mi_r; se_nxt = se_r;
    oh_nxt = oh_r; om_nxt = om_r; fr_nxt = fr_r; fc_nxt = fc_r; neg_nxt = neg_r;
    if (!err_r) begin
      unique case (phase_r)
        PH_LEAD, PH_Y1, PH_Y2, PH_Y3: begin
          if (phase_r == PH_LEAD && is_ws) begin
          end else if (!is_dig) begin
            err_nxt = 1'b1;
          end else begin
            year_nxt = 14'((year_r << 3) + (year_r << 1) + 14'(dv));
            unique case (phase_r)
              PH_LEAD: phase_nxt = PH_Y1;
              PH_Y1:   phase_nxt = PH_Y2;
              PH_Y2:   phase_nxt = PH_Y3;
              default: phase_nxt = PH_DASH1;
            endcase
          end
        end
        PH_DASH1: if (c == "-") phase_nxt = PH_M0; else err_nxt = 1'b1;
        PH_DASH2: if (c == "-") phase_nxt = PH_D0; else err_nxt = 1'b1;
        PH_C1:    if (c == ":") phase_nxt = PH_MI0; else err_nxt = 1'b1;
        PH_C2:    if (c == ":") phase_nxt = PH_S0; else err_nxt = 1'b1;
        PH_OC:    if (c == ":") phase_nxt = PH_OM0; else err_nxt = 1'b1;
        PH_M0, PH_M1: begin
          if (!is_dig) err_nxt = 1'b1;
          else begin
            mon_nxt = sh7(mon_r, dv);
            phase_nxt = (phase_r == PH_M0) ? PH_M1 : PH_DASH2;
          end
        end
        PH_D0, PH_D1: begin
          if (!is_dig) err_nxt = 1'b1;
          else begin
            day_nxt = sh7(day_r, dv);
            phase_nxt = (phase_r == PH_D0) ? PH_D1 : PH_AFTER_DATE;
          end
        end
        PH_H0, PH_H1: begin
          if (!is_dig) err_nxt = 1'b1;
          else begin
            hr_nxt = sh7(hr_r, dv);
            phase_nxt = (phase_r == PH_H0) ? PH_H1 : PH_C1;
          end
        end
        PH_MI0, PH_MI1: begin
          if (!is_dig) err_nxt = 1'b1;
          else begin
            mi_nxt = sh7(mi_r, dv);
            phase_nxt = (phase_r == PH_MI0) ? PH_MI1 : PH_C2;
          end
        end
        PH_S0, PH_S1: begin
          if (!is_dig) err_nxt = 1'b1;
          else begin
            se_nxt = sh7(se_r, dv);
            phase_nxt = (phase_r == PH_S0) ? PH_S1 : PH_AFTER_SEC;
          end
        end
        PH_OH0, PH_OH1: begin
          if (!is_dig) err_nxt = 1'b1;
          else begin
            oh_nxt = sh7(oh_r, dv);
            phase_nxt = (phase_r == PH_OH0) ? PH_OH1 : PH_OC;
          end
        end
        PH_OM0, PH_OM1: begin
          if (!is_dig) err_nxt = 1'b1;
          else begin
            om_nxt = sh7(om_r, dv);
            phase_nxt = (phase_r == PH_OM0) ? PH_OM1 : PH_TAIL;
          end
        end
        PH_AFTER_DATE: begin
          if (is_ws) phase_nxt = PH_DATE_WS;
          else if (c == "T") phase_nxt = PH_H0;
          else err_nxt = 1'b1;
        end
        PH_DATE_WS, PH_TAIL: if (!is_ws) err_nxt = 1'b1;
        PH_AFTER_SEC, PH_FRAC_FIRST, PH_FRAC: begin
          if (phase_r == PH_AFTER_SEC && c == ".") begin
            phase_nxt = PH_FRAC_FIRST;
          end else if (phase_r != PH_AFTER_SEC && is_dig) begin
            if (fc_r < 4'd9) begin
              fr_nxt = 30'((fr_r << 3) + (fr_r << 1) + 30'(dv));
              fc_nxt = fc_r + 4'd1;
            end
            phase_nxt = PH_FRAC;
          end else if (phase_r == PH_FRAC_FIRST) begin
            err_nxt = 1'b1;
          end else if (c == "Z" || is_ws) begin
            phase_nxt = PH_TAIL;
          end else if (c == "+" || c == "-") begin
            neg_nxt = (c == "-");
            phase_nxt = PH_OH0;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: err_nxt = 1'b1;
      endcase
    end
  end

  // Classification of the literal as it stands after the last character.
  always_comb begin
    leap = (year_r[1:0] == 2'b00 && yrem != 14'd0)
        || (yrem == 14'd0 && ycent[1:0] == 2'b00);
    date_ok = 1'b0;
    lim = 5'd0;
    if (mon_nxt >= 7'd1 && mon_nxt <= 7'd12 && day_nxt >= 7'd1) begin
      lim = MonthLen[4'(mon_nxt - 7'd1)];
      if (mon_nxt == 7'd2 && leap) lim = 5'd29;
      date_ok = (day_nxt <= 7'(lim));
    end
    donly = (phase_nxt == PH_AFTER_DATE) || (phase_nxt == PH_DATE_WS);
    ok = 1'b0;
    if (!err_nxt) begin
      if (donly) ok = date_ok;
      else if (phase_nxt == PH_AFTER_SEC || phase_nxt == PH_FRAC || phase_nxt == PH_TAIL)
        ok = date_ok && hr_nxt <= 7'd23 && mi_nxt <= 7'd59 && se_nxt <= 7'd59
          && oh_nxt <= 7'd23 && om_nxt <= 7'd59;
    end
  end

  assign lit_valid = in_valid && in_is_last;
  always_comb begin
    lit.ok = ok;
    lit.day_only = donly;
    lit.year = year_nxt;
    lit.month = mon_nxt[3:0];
    lit.day = day_nxt[4:0];
    lit.hour = hr_nxt[4:0];
    lit.minute = mi_nxt[5:0];
    lit.second = se_nxt[5:0];
    lit.frac = fr_nxt;
    lit.frac_cnt = fc_nxt;
    lit.off_neg = neg_nxt;
    lit.off_hour = oh_nxt[4:0];
    lit.off_minute = om_nxt[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_is_last)) begin
      phase_r <= PH_LEAD;
      err_r <= 1'b0;
      year_r <= '0; mon_r <= '0; day_r <= '0; hr_r <= '0; mi_r <= '0; se_r <= '0;
      oh_r <= '0; om_r <= '0; fr_r <= '0; fc_r <= '0; neg_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      err_r <= err_nxt;
      year_r <= year_nxt; mon_r <= mon_nxt; day_r <= day_nxt; hr_r <= hr_nxt;
      mi_r <= mi_nxt; se_r <= se_nxt; oh_r <= oh_nxt; om_r <= om_nxt;
      fr_r <= fr_nxt; fc_r <= fc_nxt; neg_r <= neg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rtp_queue.sv -----
`default_nettype none
module rtp_queue
  import rtp_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire lit_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output lit_t      rd_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  lit_t mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule
`default_nettype wire

// ----- sv/rtp_back.sv -----
`default_nettype none
module rtp_back
  import rtp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic lit_valid,
  output logic      lit_ready,
  input  wire lit_t lit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_valid_res,
  output logic [13:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic             out_day_only,
  output logic signed [38:0] out_epoch_seconds,
  output logic [29:0]      out_nanoseconds
);

  bstate_t st_r;
  lit_t    l_r;
  logic [13:0] yoe_r;       // year of era: 0..399 after shifting, era -1..24
  logic [5:0]  era_r;
  logic [8:0]  doy_r;
  logic signed [22:0] days_r;
  logic signed [38:0] secs_r;
  logic [29:0] ns_r;
  logic [3:0]  fk_r;

  logic [13:0] ysh;
  logic [3:0]  mm;
  logic [26:0] era_prod;
  logic [5:0]  era_c;
  logic [13:0] yoe_c;
  logic [18:0] cent_prod;
  logic [18:0] doe_c;

  assign lit_ready = (st_r == BS_IDLE);

  // Shifted year is nonnegative except year 0 in Jan/Feb, which lands in era -1.
  // Division by 400 and by 100 use reciprocal multiplications that are exact
  // over the ranges that reach them.
  always_comb begin
    ysh = l_r.year - ((l_r.month <= 4'd2) ? 14'd1 : 14'd0);
    mm = (l_r.month > 4'd2) ? l_r.month - 4'd3 : l_r.month + 4'd9;
    era_prod = 27'(ysh) * 27'd5243;
    era_c = era_prod[26:21];
    yoe_c = ysh - 14'(era_c) * 14'd400;
    cent_prod = 19'(yoe_r) * 19'd41;
    doe_c = 19'(yoe_r) * 19'd365 + 19'(yoe_r >> 2) - 19'(cent_prod[18:12]) + 19'(doy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BS_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (st_r)
        BS_IDLE: if (lit_valid) begin
          l_r <= lit;
          st_r <= BS_DAYS;
        end
        BS_DAYS: begin
          if (l_r.year == 14'd0 && l_r.month <= 4'd2) begin
            era_r <= 6'd63;
            yoe_r <= 14'd399;
          end else begin
            era_r <= era_c;
            yoe_r <= yoe_c;
          end
          doy_r <= DoyBase[mm] + 9'(l_r.day) - 9'd1;
          st_r <= BS_DOE;
        end
        BS_DOE: begin
          days_r <= 23'(signed'(era_r)) * 23'sd146097 + 23'(doe_c) - 23'sd719468;
          st_r <= BS_SECS;
        end
        BS_SECS: begin
          secs_r <= 39'(days_r) * 39'sd86400;
          ns_r <= l_r.frac;
          fk_r <= l_r.frac_cnt;
          st_r <= BS_FRAC;
        end
        BS_FRAC: begin
          // One decimal scale step per cycle until nine digits are reached.
          if (!l_r.day_only && fk_r < 4'd9) begin
            ns_r <= 30'((ns_r << 3) + (ns_r << 1));
            fk_r <= fk_r + 4'd1;
          end else begin
            if (!l_r.day_only) begin
              secs_r <= secs_r + 39'(l_r.hour) * 39'sd3600 + 39'(l_r.minute) * 39'sd60
                + 39'(l_r.second)
                + (l_r.off_neg ? 39'sd1 : -39'sd1)
                  * (39'(l_r.off_hour) * 39'sd3600 + 39'(l_r.off_minute) * 39'sd60);
            end else begin
              ns_r <= '0;
            end
            st_r <= BS_OUT;
          end
        end
        BS_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_valid_res <= l_r.ok;
            out_year <= l_r.ok ? l_r.year : '0;
            out_month <= l_r.ok ? l_r.month : '0;
            out_day <= l_r.ok ? l_r.day : '0;
            out_day_only <= l_r.ok && l_r.day_only;
            out_epoch_seconds <= l_r.ok ? secs_r : '0;
            out_nanoseconds <= l_r.ok ? ns_r : '0;
            st_r <= BS_IDLE;
          end
        end
        default: st_r <= BS_IDLE;
      endcase
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
